### rtl/tstp_pkg.sv
package tstp_pkg;

  localparam int MAX_TILES = 1024;
  localparam int SLOT_W    = $clog2(MAX_TILES);
  localparam int CNT_W     = SLOT_W + 1;

  localparam int IN_BITS    = SLOT_W + 1;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 3 + 2 * SLOT_W + CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SWAP,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [SLOT_W-1:0] data;
  } slot_wr_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic              data;
  } grp_wr_t;

  typedef struct packed {
    logic [SLOT_W-1:0] l2p_addr;
    logic [SLOT_W-1:0] p2l_addr;
  } rd_req_t;

  typedef struct packed {
    logic              busy;
    logic [SLOT_W-1:0] addr;
  } clr_t;

  typedef struct packed {
    logic              bad_tile;
    logic [CNT_W-1:0]  boundary_now;
    logic [SLOT_W-1:0] slot_b;
    logic [SLOT_W-1:0] slot_a;
    logic              swap_valid;
    logic              changed;
  } res_t;

endpackage

### rtl/two_set_tile_partition_unit.sv
// channel  | direction | tdata fields, lowest bit first
// s_axis   | in        | tile[9:0], to_group[10]
// m_axis   | out       | changed, swap_valid, slot_a, slot_b, boundary_now, bad_tile
// cfg      | in        | tile_count, 11 bits, write only
//
// an item is read from the three maps, then updated in ST_READ, and also in ST_SWAP when slots
// are swapped: the l2p and p2l maps each have a single write port and need a second write
// after reset and after each tile_count write the slot maps are cleared to identity and the
// group map to zero, one entry per cycle, with s_axis_tready low
// a result waits in the output register; the next item is taken meanwhile
// and held in its last cycle until the output register frees up
module two_set_tile_partition_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tstp_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [tstp_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // tile, to_group
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // changed, swap_valid, slot_a, slot_b, boundary_now, bad_tile
  output logic [tstp_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  import tstp_pkg::*;

  logic [CNT_W-1:0]  tile_count_q, tile_count_d;
  logic [CNT_W-1:0]  cfg_count;
  logic              m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic              out_free;

  clr_t              clr;
  rd_req_t           rd;
  slot_wr_t          l2p_wr, p2l_wr;
  grp_wr_t           grp_wr;
  logic [SLOT_W-1:0] l2p_rdata, p2l_rdata;
  logic              grp_rdata;
  logic              push;
  res_t              res;

  logic              l2p_we, p2l_we, grp_we;
  logic [SLOT_W-1:0] l2p_waddr, l2p_wdata, p2l_waddr, p2l_wdata, grp_waddr;
  logic              grp_wdata;

  // counts above the table size saturate
  assign cfg_count = (cfg_wdata_i > CNT_W'(MAX_TILES)) ? CNT_W'(MAX_TILES) : cfg_wdata_i;

  always_comb begin
    tile_count_d = cfg_we_i ? cfg_count : tile_count_q;
  end

  tstp_clear u_clear (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_we_i (cfg_we_i),
    .clr_o    (clr)
  );

  tstp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_count_i  (cfg_count),
    .tile_count_i (tile_count_q),
    .clr_busy_i   (clr.busy),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_tile_i    (s_axis_tdata[SLOT_W-1:0]),
    .in_want_i    (s_axis_tdata[SLOT_W]),
    .rd_o         (rd),
    .l2p_rdata_i  (l2p_rdata),
    .p2l_rdata_i  (p2l_rdata),
    .grp_rdata_i  (grp_rdata),
    .l2p_wr_o     (l2p_wr),
    .p2l_wr_o     (p2l_wr),
    .grp_wr_o     (grp_wr),
    .out_free_i   (out_free),
    .push_o       (push),
    .res_o        (res)
  );

  // clearing pass owns the write ports while it runs
  always_comb begin
    l2p_we    = clr.busy | l2p_wr.en;
    l2p_waddr = clr.busy ? clr.addr : l2p_wr.addr;
    l2p_wdata = clr.busy ? clr.addr : l2p_wr.data;
    p2l_we    = clr.busy | p2l_wr.en;
    p2l_waddr = clr.busy ? clr.addr : p2l_wr.addr;
    p2l_wdata = clr.busy ? clr.addr : p2l_wr.data;
    grp_we    = clr.busy | grp_wr.en;
    grp_waddr = clr.busy ? clr.addr : grp_wr.addr;
    grp_wdata = clr.busy ? 1'b0 : grp_wr.data;
  end

  tstp_ram #(.Width(SLOT_W), .Depth(MAX_TILES)) u_l2p_ram (
    .clk_i   (clk_i),
    .we_i    (l2p_we),
    .waddr_i (l2p_waddr),
    .wdata_i (l2p_wdata),
    .raddr_i (rd.l2p_addr),
    .rdata_o (l2p_rdata)
  );

  tstp_ram #(.Width(SLOT_W), .Depth(MAX_TILES)) u_p2l_ram (
    .clk_i   (clk_i),
    .we_i    (p2l_we),
    .waddr_i (p2l_waddr),
    .wdata_i (p2l_wdata),
    .raddr_i (rd.p2l_addr),
    .rdata_o (p2l_rdata)
  );

  tstp_ram #(.Width(1), .Depth(MAX_TILES)) u_grp_ram (
    .clk_i   (clk_i),
    .we_i    (grp_we),
    .waddr_i (grp_waddr),
    .wdata_i (grp_wdata),
    .raddr_i (rd.l2p_addr),
    .rdata_o (grp_rdata)
  );

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (push) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_count_q <= CNT_W'(MAX_TILES);
      m_valid_q    <= 1'b0;
    end else begin
      tile_count_q <= tile_count_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      m_data_q <= OUT_DATA_W'({res.bad_tile, res.boundary_now, res.slot_b, res.slot_a,
                               res.swap_valid, res.changed});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

### rtl/tstp_ram.sv
module tstp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tstp_clear.sv
module tstp_clear (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  output tstp_pkg::clr_t clr_o
);

  import tstp_pkg::*;

  logic              busy_q, busy_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (cfg_we_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + SLOT_W'(1);
      if (cnt_q == SLOT_W'(MAX_TILES - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  assign clr_o.busy = busy_q;
  assign clr_o.addr = cnt_q;

endmodule

### rtl/tstp_ctrl.sv
module tstp_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tstp_pkg::CNT_W-1:0]    cfg_count_i,
  input  logic [tstp_pkg::CNT_W-1:0]    tile_count_i,
  input  logic                          clr_busy_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tstp_pkg::SLOT_W-1:0]   in_tile_i,
  input  logic                          in_want_i,
  output tstp_pkg::rd_req_t             rd_o,
  input  logic [tstp_pkg::SLOT_W-1:0]   l2p_rdata_i,
  input  logic [tstp_pkg::SLOT_W-1:0]   p2l_rdata_i,
  input  logic                          grp_rdata_i,
  output tstp_pkg::slot_wr_t            l2p_wr_o,
  output tstp_pkg::slot_wr_t            p2l_wr_o,
  output tstp_pkg::grp_wr_t             grp_wr_o,
  input  logic                          out_free_i,
  output logic                          push_o,
  output tstp_pkg::res_t                res_o
);

  import tstp_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  bnd_q, bnd_d;
  logic [SLOT_W-1:0] tile_q, tgt_q, old_q, other_q;
  logic              want_q, bad_q;
  res_t              res_q;

  logic [CNT_W-1:0]  tgt_wide;
  logic [SLOT_W-1:0] tgt_in;
  logic              act, swap;
  logic [CNT_W-1:0]  bnd_new;
  res_t              res_now;

  // boundary slot the tile would move into, clamped to the last slot
  always_comb begin
    tgt_wide = in_want_i ? (bnd_q - CNT_W'(1)) : bnd_q;
    if (tgt_wide >= CNT_W'(MAX_TILES)) begin
      tgt_in = SLOT_W'(MAX_TILES - 1);
    end else begin
      tgt_in = tgt_wide[SLOT_W-1:0];
    end
  end

  always_comb begin
    act  = !bad_q && (grp_rdata_i != want_q);
    swap = act && (l2p_rdata_i != tgt_q);
    bnd_new = bnd_q;
    if (act) begin
      if (want_q) begin
        if (bnd_q != '0) begin
          bnd_new = bnd_q - CNT_W'(1);
        end
      end else if (bnd_q < tile_count_i) begin
        bnd_new = bnd_q + CNT_W'(1);
      end
    end
    res_now.changed      = act;
    res_now.swap_valid   = swap;
    res_now.slot_a       = act ? l2p_rdata_i : '0;
    res_now.slot_b       = act ? tgt_q : '0;
    res_now.boundary_now = bnd_new;
    res_now.bad_tile     = bad_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !clr_busy_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (swap) begin
          state_d = ST_SWAP;
        end else if (out_free_i) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_SWAP: begin
        state_d = out_free_i ? ST_IDLE : ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    rd_o.l2p_addr = in_tile_i;
    rd_o.p2l_addr = tgt_in;
    l2p_wr_o.en   = 1'b0;
    l2p_wr_o.addr = tile_q;
    l2p_wr_o.data = tgt_q;
    p2l_wr_o.en   = 1'b0;
    p2l_wr_o.addr = tgt_q;
    p2l_wr_o.data = tile_q;
    grp_wr_o.en   = 1'b0;
    grp_wr_o.addr = tile_q;
    grp_wr_o.data = want_q;
    push_o        = 1'b0;
    res_o         = res_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !clr_busy_i;
      end
      ST_READ: begin
        grp_wr_o.en = act;
        l2p_wr_o.en = swap;
        p2l_wr_o.en = swap;
        push_o      = !swap && out_free_i;
        res_o       = res_now;
      end
      ST_SWAP: begin
        // displaced tile takes the old slot
        l2p_wr_o.en   = 1'b1;
        l2p_wr_o.addr = other_q;
        l2p_wr_o.data = old_q;
        p2l_wr_o.en   = 1'b1;
        p2l_wr_o.addr = old_q;
        p2l_wr_o.data = other_q;
        push_o        = out_free_i;
      end
      ST_PUSH: begin
        push_o = out_free_i;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    bnd_d = bnd_q;
    if (cfg_we_i) begin
      bnd_d = cfg_count_i;
    end else if (state_q == ST_READ) begin
      bnd_d = bnd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bnd_q   <= CNT_W'(MAX_TILES);
    end else begin
      state_q <= state_d;
      bnd_q   <= bnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tile_q <= in_tile_i;
      want_q <= in_want_i;
      bad_q  <= ({1'b0, in_tile_i} >= tile_count_i);
      tgt_q  <= tgt_in;
    end
    if (state_q == ST_READ) begin
      old_q   <= l2p_rdata_i;
      other_q <= p2l_rdata_i;
      res_q   <= res_now;
    end
  end

endmodule
